/* rtl/core/mwd_pkg.sv */
package mwd_pkg;

  localparam int WORD_BITS  = 64;
  localparam int FIELD_BITS = 64;
  localparam int CNT_BITS   = $clog2(2 * WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

/* rtl/core/mwd_if.sv */
interface mwd_in_if;
  logic            valid;
  logic            ready;
  mwd_pkg::field_t dividend_word;
  logic            final_word;

  modport source(output valid, output dividend_word, output final_word, input ready);
  modport sink(input valid, input dividend_word, input final_word, output ready);
endinterface

interface mwd_out_if;
  logic            valid;
  logic            ready;
  mwd_pkg::field_t quotient_word;
  mwd_pkg::field_t remainder_out;
  logic            last_out;
  logic            zero_divisor;

  modport source(output valid, output quotient_word, output remainder_out,
                 output last_out, output zero_divisor, input ready);
  modport sink(input valid, input quotient_word, input remainder_out,
               input last_out, input zero_divisor, output ready);
endinterface

interface mwd_cfg_if;
  logic            valid;
  logic            ready;
  mwd_pkg::field_t divisor;

  modport source(output valid, output divisor, input ready);
  modport sink(input valid, input divisor, output ready);
endinterface

/* rtl/core/mwd_step.sv */
module mwd_step (
  input  mwd_pkg::word_t rem_i,
  input  logic           bit_i,
  input  mwd_pkg::word_t den_i,
  output mwd_pkg::word_t rem_o,
  output logic           qbit_o
);

  mwd_pkg::word_t shifted;
  logic           take;

  always_comb begin
    shifted = {rem_i[mwd_pkg::WORD_BITS-2:0], bit_i};
    take    = rem_i[mwd_pkg::WORD_BITS-1] || (shifted >= den_i);
    rem_o   = take ? (shifted - den_i) : shifted;
    qbit_o  = take;
  end

endmodule

/* rtl/core/multiword_by_word_divider.sv */
// Channel  Dir  Payload                                              Handshake
// cfg_ch   in   divisor                                              valid/ready
// in_ch    in   dividend_word, final_word                            valid/ready
// out_ch   out  quotient_word, remainder_out, last_out, zero_divisor valid/ready
//
// A request steps through the WORD_BITS word bits when the running remainder is
// below the divisor, else 2 * WORD_BITS bits of remainder and word, one quotient
// bit per cycle via the shared shift/compare/subtract step. Zero divisors skip it.
// Synchronous active-low reset clears the running remainder and sets divisor 1.
// in_ch is ready only when idle; a result waits in the output register and
// the next request is accepted meanwhile. Config is always ready.
module multiword_by_word_divider (
  input  logic     clk,
  input  logic     rst_n,
  mwd_cfg_if.sink  cfg_ch,
  mwd_in_if.sink   in_ch,
  mwd_out_if.source out_ch
);

  localparam int W = mwd_pkg::WORD_BITS;

  mwd_pkg::state_t state_r, state_nxt;
  mwd_pkg::cnt_t   cnt_r, cnt_nxt;
  logic [2*W-1:0]  bits_r, bits_nxt;
  mwd_pkg::word_t  r_r, r_nxt;
  mwd_pkg::word_t  q_r, q_nxt;
  logic            last_r, last_nxt;
  logic            zero_r, zero_nxt;
  mwd_pkg::word_t  rem_run_r, rem_run_nxt;
  mwd_pkg::word_t  den_r;
  logic            out_valid_r, out_valid_nxt;
  mwd_pkg::field_t out_q_r, out_q_nxt;
  mwd_pkg::field_t out_rem_r, out_rem_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_zero_r, out_zero_nxt;

  logic            in_acc;
  logic            out_load;
  logic            out_free;
  mwd_pkg::word_t  word_in;
  mwd_pkg::word_t  step_rem;
  logic            step_q;

  mwd_step u_step (
    .rem_i  (r_r),
    .bit_i  (bits_r[2*W-1]),
    .den_i  (den_r),
    .rem_o  (step_rem),
    .qbit_o (step_q)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == mwd_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign word_in      = in_ch.dividend_word[W-1:0];

  assign out_ch.valid         = out_valid_r;
  assign out_ch.quotient_word = out_q_r;
  assign out_ch.remainder_out = out_rem_r;
  assign out_ch.last_out      = out_last_r;
  assign out_ch.zero_divisor  = out_zero_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    bits_nxt     = bits_r;
    r_nxt        = r_r;
    q_nxt        = q_r;
    last_nxt     = last_r;
    zero_nxt     = zero_r;
    rem_run_nxt  = rem_run_r;
    out_load     = 1'b0;
    case (state_r)
      mwd_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_ch.final_word;
          if (den_r == '0) begin
            q_nxt     = '1;
            r_nxt     = '0;
            zero_nxt  = 1'b1;
            state_nxt = mwd_pkg::ST_FINISH;
          end else begin
            q_nxt     = '0;
            zero_nxt  = 1'b0;
            state_nxt = mwd_pkg::ST_RUN;
            if (rem_run_r < den_r) begin
              r_nxt    = rem_run_r;
              bits_nxt = {word_in, mwd_pkg::word_t'(0)};
              cnt_nxt  = mwd_pkg::CNT_BITS'(W);
            end else begin
              r_nxt    = '0;
              bits_nxt = {rem_run_r, word_in};
              cnt_nxt  = mwd_pkg::CNT_BITS'(2 * W);
            end
          end
        end
      end
      mwd_pkg::ST_RUN: begin
        r_nxt    = step_rem;
        q_nxt    = {q_r[W-2:0], step_q};
        bits_nxt = bits_r << 1;
        cnt_nxt  = cnt_r - mwd_pkg::CNT_BITS'(1);
        if (cnt_r == mwd_pkg::CNT_BITS'(1)) begin
          state_nxt = mwd_pkg::ST_FINISH;
        end
      end
      mwd_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load    = 1'b1;
          rem_run_nxt = last_r ? '0 : r_r;
          state_nxt   = mwd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwd_pkg::ST_IDLE;
      end
    endcase

    out_q_nxt    = out_q_r;
    out_rem_nxt  = out_rem_r;
    out_last_nxt = out_last_r;
    out_zero_nxt = out_zero_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_q_nxt     = mwd_pkg::field_t'(q_r);
      out_rem_nxt   = mwd_pkg::field_t'(r_r);
      out_last_nxt  = last_r;
      out_zero_nxt  = zero_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwd_pkg::ST_IDLE;
      rem_run_r   <= '0;
      den_r       <= mwd_pkg::word_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_run_r   <= rem_run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        den_r <= cfg_ch.divisor[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    bits_r     <= bits_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    last_r     <= last_nxt;
    zero_r     <= zero_nxt;
    out_q_r    <= out_q_nxt;
    out_rem_r  <= out_rem_nxt;
    out_last_r <= out_last_nxt;
    out_zero_r <= out_zero_nxt;
  end

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwd_pkg::ST_RUN) |-> (cnt_r != '0))
    else $error("division running with no steps left");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (zero_r || (r_r < den_r)))
    else $error("remainder not below divisor");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (rem_run_r == '0))
    else $error("running remainder kept after final word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request accepted while busy");

endmodule

/* verif/multiword_by_word_divider_tb.sv */
module multiword_by_word_divider_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mwd_pkg::field_t word;
    logic            last;
  } dividend_req_t;

  typedef struct packed {
    mwd_pkg::field_t quotient;
    mwd_pkg::field_t remainder;
    logic            last;
    logic            zero;
  } quotient_res_t;

  logic clk = 1'b0;
  logic rst_n;

  mwd_cfg_if cfg_ch ();
  mwd_in_if  in_ch ();
  mwd_out_if out_ch ();

  multiword_by_word_divider uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  dividend_req_t pending_words[$];
  quotient_res_t expected_quotients[$];

  mwd_pkg::field_t divisor_model = mwd_pkg::field_t'(1);
  mwd_pkg::word_t  carry_rem     = '0;

  int  words_queued   = 0;
  int  divisor_writes = 0;
  int  mismatches     = 0;
  int  send_gap       = 0;
  int  send_gap_max   = 6;
  int  recv_stall     = 0;
  int  recv_stall_max = 6;
  bit  in_busy        = 1'b0;

  function automatic quotient_res_t divide_word(input mwd_pkg::field_t dividend,
                                                input logic last);
    quotient_res_t                   res;
    mwd_pkg::word_t                  den;
    logic [2*mwd_pkg::WORD_BITS-1:0] num;
    logic [2*mwd_pkg::WORD_BITS-1:0] quo;
    logic [2*mwd_pkg::WORD_BITS-1:0] rem;
    den      = divisor_model[mwd_pkg::WORD_BITS-1:0];
    res      = '0;
    res.last = last;
    if (den == '0) begin
      res.quotient = mwd_pkg::field_t'(mwd_pkg::word_t'('1));
      res.zero     = 1'b1;
      carry_rem    = '0;
    end else begin
      num           = {carry_rem, dividend[mwd_pkg::WORD_BITS-1:0]};
      quo           = num / {{mwd_pkg::WORD_BITS{1'b0}}, den};
      rem           = num % {{mwd_pkg::WORD_BITS{1'b0}}, den};
      res.quotient  = mwd_pkg::field_t'(quo[mwd_pkg::WORD_BITS-1:0]);
      res.remainder = mwd_pkg::field_t'(rem[mwd_pkg::WORD_BITS-1:0]);
      carry_rem     = last ? mwd_pkg::word_t'(0) : rem[mwd_pkg::WORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic mwd_pkg::field_t rand_word();
    mwd_pkg::field_t w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = mwd_pkg::field_t'(1) << $urandom_range(0, mwd_pkg::WORD_BITS - 1);
      3: w = mwd_pkg::field_t'($urandom_range(0, 255));
      4: w = w >> $urandom_range(1, mwd_pkg::WORD_BITS - 1);
      default: ;
    endcase
    return w;
  endfunction

  function automatic mwd_pkg::field_t rand_divisor();
    mwd_pkg::field_t d;
    d = {$urandom(), $urandom()};
    case ($urandom_range(0, 15))
      0: d = '0;
      1: d = mwd_pkg::field_t'(1);
      2: d = '1;
      3: d = mwd_pkg::field_t'($urandom_range(2, 1000));
      4, 5: d = d >> $urandom_range(1, mwd_pkg::WORD_BITS - 1);
      6: d = d | (mwd_pkg::field_t'(1) << (mwd_pkg::WORD_BITS - 1));
      default: ;
    endcase
    return d;
  endfunction

  task automatic queue_word(input mwd_pkg::field_t word, input logic last);
    pending_words.push_back('{word: word, last: last});
    words_queued++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_busy || expected_quotients.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_divisor(input mwd_pkg::field_t value);
    int seen;
    wait_idle();
    seen = divisor_writes;
    cfg_ch.divisor <= value;
    cfg_ch.valid   <= 1'b1;
    do @(negedge clk); while (divisor_writes == seen);
    cfg_ch.valid <= 1'b0;
  endtask

  // request acceptance, result checking and register tracking
  always @(posedge clk) begin
    quotient_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      recv_stall = $urandom_range(0, recv_stall_max);
      if (expected_quotients.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: q=%h r=%h last=%b zero=%b", out_ch.quotient_word,
                   out_ch.remainder_out, out_ch.last_out, out_ch.zero_divisor);
      end else begin
        want = expected_quotients.pop_front();
        if (out_ch.quotient_word !== want.quotient || out_ch.remainder_out !== want.remainder ||
            out_ch.last_out !== want.last || out_ch.zero_divisor !== want.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected q=%h r=%h last=%b zero=%b, got q=%h r=%h last=%b zero=%b",
                     want.quotient, want.remainder, want.last, want.zero,
                     out_ch.quotient_word, out_ch.remainder_out, out_ch.last_out,
                     out_ch.zero_divisor);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_quotients.push_back(divide_word(in_ch.dividend_word, in_ch.final_word));
      in_busy  = 1'b0;
      send_gap = $urandom_range(0, send_gap_max);
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      divisor_model = cfg_ch.divisor;
      divisor_writes++;
    end
  end

  // request driver: hold until accepted, idle only while the block is ready
  always @(negedge clk) begin
    dividend_req_t req;
    if (rst_n) begin
      if (!in_busy) begin
        if (send_gap > 0) begin
          if (in_ch.ready) send_gap--;
        end else if (pending_words.size() != 0) begin
          req = pending_words.pop_front();
          in_ch.dividend_word <= req.word;
          in_ch.final_word    <= req.last;
          in_busy = 1'b1;
        end
      end
      in_ch.valid <= in_busy;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("multiword_by_word_divider_tb failed");
    $finish;
  end

  initial begin
    int     numbers;
    int     len;
    bit     cut;
    rst_n               = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.divisor      = '0;
    in_ch.valid         = 1'b0;
    in_ch.dividend_word = '0;
    in_ch.final_word    = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_word('1, 1'b0);
    queue_word('0, 1'b1);

    set_divisor('1);
    queue_word('1, 1'b0);
    queue_word(mwd_pkg::field_t'(1) << (mwd_pkg::WORD_BITS - 1), 1'b0);
    queue_word('1, 1'b1);

    set_divisor('0);
    queue_word('1, 1'b0);
    queue_word(mwd_pkg::field_t'(5), 1'b1);

    set_divisor(mwd_pkg::field_t'(7));
    queue_word('1, 1'b0);
    queue_word('0, 1'b0);
    queue_word('1, 1'b1);

    set_divisor(mwd_pkg::field_t'(1) << (mwd_pkg::WORD_BITS - 1));
    queue_word('1, 1'b0);
    queue_word(mwd_pkg::field_t'(12345), 1'b1);

    // carried remainder above the new divisor
    set_divisor('1);
    queue_word(mwd_pkg::field_t'(mwd_pkg::word_t'('1) - mwd_pkg::word_t'(1)), 1'b0);
    set_divisor(mwd_pkg::field_t'(3));
    queue_word(mwd_pkg::field_t'(5), 1'b1);

    // zero divisor in mid-number drops the carried remainder
    set_divisor(mwd_pkg::field_t'(1000));
    queue_word('1, 1'b0);
    set_divisor('0);
    queue_word(mwd_pkg::field_t'(7), 1'b0);
    set_divisor(mwd_pkg::field_t'(1000));
    queue_word(mwd_pkg::field_t'(7), 1'b1);

    while (words_queued < 1420) begin
      set_divisor(rand_divisor());
      send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
      recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      numbers        = $urandom_range(1, 4);
      cut            = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < numbers; n++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int w = 0; w < len; w++)
          queue_word(rand_word(), (w == len - 1) && !(cut && n == numbers - 1));
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_quotients.size() == 0) begin
      $display("multiword_by_word_divider_tb passed");
    end else begin
      $display("multiword_by_word_divider_tb failed");
    end
    $finish;
  end

endmodule
